// ===== src/hkrd_pkg.sv =====
`timescale 1ns / 1ps

package hkrd_pkg;

  localparam int KeySlots  = 6;
  localparam int InBytes   = 9;
  localparam int MaxEvents = 12;
  localparam int NumCand   = 2 * KeySlots;

  localparam int IdxW     = $clog2(NumCand);
  localparam int SlotW    = (KeySlots > 1) ? $clog2(KeySlots) : 1;
  localparam int CntW     = $clog2(MaxEvents + 1);
  localparam int ByteSelW = $clog2(InBytes);
  localparam int BIdxW    = $clog2(InBytes + KeySlots + 3);
  localparam int LenCmpW  = 5;

  typedef logic [7:0] key_t;
  typedef logic [KeySlots-1:0][7:0] key_set_t;
  typedef logic [NumCand-1:0] cand_mask_t;

  typedef struct packed {
    logic       disconnect;
    logic [3:0] report_length;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
    logic [7:0] byte7;
    logic [7:0] byte8;
  } in_item_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic [7:0] modifier_bits;
    logic       pressed;
    logic       last_event;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic clear;
  } seq_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } seq_state_e;

endpackage

// ===== src/hkrd_ifs.sv =====
`timescale 1ns / 1ps

interface hkrd_in_if;
  logic              valid;
  logic              ready;
  hkrd_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hkrd_out_if;
  logic               valid;
  logic               ready;
  hkrd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hkrd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/hkrd_match.sv =====
`timescale 1ns / 1ps

module hkrd_match (
  input  hkrd_pkg::key_t     key_i,
  input  hkrd_pkg::key_set_t set_i,
  output logic               hit_o
);

  logic found;

  always_comb begin
    found = 1'b0;
    for (int i = 0; i < hkrd_pkg::KeySlots; i++) begin
      if (set_i[i] == key_i) begin
        found = 1'b1;
      end
    end
  end

  // nonzero key that is absent from the other set
  assign hit_o = (key_i != 8'd0) && !found;

endmodule

// ===== src/hkrd_seq.sv =====
`timescale 1ns / 1ps

module hkrd_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hkrd_pkg::seq_cmd_t   cmd_i,
  input  logic [7:0]           mods_i,
  input  hkrd_pkg::key_set_t   keys_i,
  output logic                 busy_o,
  hkrd_out_if.source           out_o
);

  localparam int KeySlots = hkrd_pkg::KeySlots;
  localparam int IdxW     = hkrd_pkg::IdxW;
  localparam int SlotW    = hkrd_pkg::SlotW;
  localparam int CntW     = hkrd_pkg::CntW;
  localparam int NumCand  = hkrd_pkg::NumCand;

  hkrd_pkg::seq_state_e state_q, state_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  hkrd_pkg::cand_mask_t mask_q, mask_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  hkrd_pkg::key_set_t   prev_q, prev_d;
  hkrd_pkg::key_set_t   new_q, new_d;
  logic [7:0]           mods_q, mods_d;
  logic                 out_valid_q, out_valid_d;
  hkrd_pkg::out_item_t  out_q, out_d;

  logic                 is_press;
  logic [IdxW-1:0]      rel_idx;
  logic [SlotW-1:0]     slot;
  hkrd_pkg::key_t       cand_key;
  hkrd_pkg::key_set_t   cand_set;
  logic                 hit;
  logic                 out_free;
  logic                 load;
  hkrd_pkg::cand_mask_t rest;
  logic                 last;

  assign is_press = idx_q < IdxW'(KeySlots);
  assign rel_idx  = idx_q - IdxW'(KeySlots);
  assign slot     = is_press ? idx_q[SlotW-1:0] : rel_idx[SlotW-1:0];
  assign cand_key = is_press ? new_q[slot] : prev_q[slot];
  assign cand_set = is_press ? prev_q : new_q;

  hkrd_match u_match (
    .key_i (cand_key),
    .set_i (cand_set),
    .hit_o (hit)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign rest     = mask_q >> idx_q;
  assign last     = (rest[NumCand-1:1] == '0);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    mask_d  = mask_q;
    cnt_d   = cnt_q;
    prev_d  = prev_q;
    new_d   = new_q;
    mods_d  = mods_q;
    load    = 1'b0;
    unique case (state_q)
      hkrd_pkg::S_IDLE: begin
        if (cmd_i.clear) begin
          prev_d = '0;
        end else if (cmd_i.start) begin
          new_d   = keys_i;
          mods_d  = mods_i;
          idx_d   = '0;
          mask_d  = '0;
          cnt_d   = '0;
          state_d = hkrd_pkg::S_SCAN;
        end
      end
      hkrd_pkg::S_SCAN: begin
        if (hit && (cnt_q != CntW'(hkrd_pkg::MaxEvents))) begin
          mask_d[idx_q] = 1'b1;
          cnt_d         = cnt_q + 1'b1;
        end
        if (idx_q == IdxW'(NumCand - 1)) begin
          idx_d = '0;
          if (mask_d == '0) begin
            prev_d  = new_q;
            state_d = hkrd_pkg::S_IDLE;
          end else begin
            state_d = hkrd_pkg::S_EMIT;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      hkrd_pkg::S_EMIT: begin
        if (mask_q[idx_q]) begin
          if (out_free) begin
            load = 1'b1;
            if (last) begin
              prev_d  = new_q;
              state_d = hkrd_pkg::S_IDLE;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: state_d = hkrd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_d.key_code      = cand_key;
      out_d.modifier_bits = mods_q;
      out_d.pressed       = is_press;
      out_d.last_event    = last;
      out_valid_d         = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hkrd_pkg::S_IDLE;
      idx_q       <= '0;
      mask_q      <= '0;
      cnt_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      mask_q      <= mask_d;
      cnt_q       <= cnt_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q  <= new_d;
    mods_q <= mods_d;
    out_q  <= out_d;
  end

  assign busy_o      = (state_q != hkrd_pkg::S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start || cmd_i.clear) |-> state_q == hkrd_pkg::S_IDLE)
    else $error("command while sequencer busy");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(hkrd_pkg::MaxEvents))
    else $error("event count above cap");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hkrd_pkg::S_SCAN && state_d == hkrd_pkg::S_EMIT) |-> mask_d != '0)
    else $error("emit phase with no events");

  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hkrd_pkg::S_SCAN && idx_q != IdxW'(NumCand - 1))
      |=> state_q == hkrd_pkg::S_SCAN)
    else $error("scan ended early");

  a_load_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (state_q == hkrd_pkg::S_EMIT && cand_key != 8'd0))
    else $error("zero key code emitted");
`endif

endmodule

// ===== src/hid_keyboard_report_differ.sv =====
`timescale 1ns / 1ps

// Keyboard report differ.
// in_i carries one item per transfer: a disconnect flag or a raw report of
// up to nine bytes plus its length. cfg_i writes the report ID to strip
// (zero: no ID); it is always ready. It is to be written only while idle;
// the block does not enforce this. out_o carries key press/release events,
// presses first, then releases; last_event marks the final event of a report.
// A report of valid length starts a scan of every key slot, new and previous,
// one key slot per cycle through the shared set-membership compare unit;
// if it finds events, the slots are then walked up to the last one to emit them.
// A disconnect or a report of any other length starts no scan.
// in_i.ready is low while a report is scanned or its events emitted.
// Events leave through an output register, so the next item can be taken
// while the final event waits; a stalled receiver stalls event emission.
// Reset clears the stored keys, the report ID and the output valid.

module hid_keyboard_report_differ (
  input  logic        clk_i,
  input  logic        rst_ni,
  hkrd_cfg_if.sink    cfg_i,
  hkrd_in_if.sink     in_i,
  hkrd_out_if.source  out_o
);

  localparam int KeySlots = hkrd_pkg::KeySlots;
  localparam int InBytes  = hkrd_pkg::InBytes;
  localparam int BIdxW    = hkrd_pkg::BIdxW;
  localparam int LenCmpW  = hkrd_pkg::LenCmpW;

  logic [7:0]         report_id_q;
  logic               busy;
  logic               accept;
  logic [7:0]         bytes [InBytes];
  logic               strip;
  logic [3:0]         len_s;
  logic               len_long;
  logic               len_short;
  logic [BIdxW-1:0]   first;
  logic [BIdxW-1:0]   pos [KeySlots];
  hkrd_pkg::key_set_t keys;
  logic [7:0]         mods;
  hkrd_pkg::seq_cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_id_q <= 8'd0;
    end else if (cfg_i.valid) begin
      report_id_q <= cfg_i.data;
    end
  end

  assign in_i.ready = !busy;
  assign accept     = in_i.valid && !busy;

  assign bytes[0] = in_i.data.byte0;
  assign bytes[1] = in_i.data.byte1;
  assign bytes[2] = in_i.data.byte2;
  assign bytes[3] = in_i.data.byte3;
  assign bytes[4] = in_i.data.byte4;
  assign bytes[5] = in_i.data.byte5;
  assign bytes[6] = in_i.data.byte6;
  assign bytes[7] = in_i.data.byte7;
  assign bytes[8] = in_i.data.byte8;

  assign strip = (report_id_q != 8'd0) && (in_i.data.report_length != 4'd0)
              && (in_i.data.byte0 == report_id_q);
  assign len_s     = in_i.data.report_length - {3'd0, strip};
  assign len_long  = {1'b0, len_s} == LenCmpW'(KeySlots + 2);
  assign len_short = {1'b0, len_s} == LenCmpW'(KeySlots + 1);
  assign first     = BIdxW'(strip) + (len_long ? BIdxW'(2) : BIdxW'(1));
  assign mods      = strip ? in_i.data.byte1 : in_i.data.byte0;

  always_comb begin
    for (int i = 0; i < KeySlots; i++) begin
      pos[i] = first + BIdxW'(i);
      if (pos[i] < BIdxW'(InBytes)) begin
        keys[i] = bytes[pos[i][hkrd_pkg::ByteSelW-1:0]];
      end else begin
        keys[i] = 8'd0;
      end
    end
  end

  assign cmd.clear = accept && in_i.data.disconnect;
  assign cmd.start = accept && !in_i.data.disconnect && (len_long || len_short);

  hkrd_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .mods_i (mods),
    .keys_i (keys),
    .busy_o (busy),
    .out_o  (out_o)
  );

endmodule
